// ===== design/triangle_element_stiffness_unit_defines.svh =====
// Assertion macros for the triangle element stiffness unit.
`ifndef TRIANGLE_ELEMENT_STIFFNESS_UNIT_DEFINES_SVH
`define TRIANGLE_ELEMENT_STIFFNESS_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define TES_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TES_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TES_ASSERT_IMP(label, clk, rst, ante, cons)
`define TES_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== design/tes_pkg.sv =====
package tes_pkg;
  localparam int unsigned MaxNodesDefault = 65536;
  localparam int unsigned NodeW = 16;
  localparam int unsigned CoordW = 24;
  localparam int unsigned DiffW = 25;
  localparam int unsigned ProdW = 50;
  localparam int unsigned DetW = 51;
  localparam int unsigned NumW = 51;
  localparam int unsigned ValW = 32;
  localparam int unsigned DivW = 66;
  localparam int unsigned QW = 66;
  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [NodeW-1:0] node_first;
    logic [NodeW-1:0] node_second;
    logic [NodeW-1:0] node_third;
    logic signed [CoordW-1:0] x_first;
    logic signed [CoordW-1:0] y_first;
    logic signed [CoordW-1:0] x_second;
    logic signed [CoordW-1:0] y_second;
    logic signed [CoordW-1:0] x_third;
    logic signed [CoordW-1:0] y_third;
  } tri_t;

  typedef struct packed {
    logic [NodeW-1:0] row_node;
    logic [NodeW-1:0] column_node;
    logic signed [ValW-1:0] contribution;
    logic degenerate;
    logic saturated;
    logic last_entry;
  } entry_t;

  // Classified triangle handed from front to back.
  typedef struct packed {
    logic [2:0][NodeW-1:0] node;
    logic signed [2:0][DiffW-1:0] bb;
    logic signed [2:0][DiffW-1:0] cc;
    logic [DetW-1:0] det_mag;
    logic zero;
  } job_t;
endpackage

// ===== design/tes_stream_if.sv =====
interface tes_stream_if #(parameter type payload_t = logic) (input logic clk);
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/tes_front.sv =====
module tes_front #(
  parameter int unsigned MAX_NODES = tes_pkg::MaxNodesDefault
) (
  input  logic clk,
  input  logic rst,
  tes_stream_if.sink in,
  output logic job_valid,
  output tes_pkg::job_t job,
  input  logic job_ready
);
  // Stage 1: differences and determinant products.
  logic s1_valid;
  logic [2:0][tes_pkg::NodeW-1:0] s1_node;
  logic signed [2:0][tes_pkg::DiffW-1:0] s1_bb, s1_cc;
  logic signed [tes_pkg::ProdW-1:0] s1_p0, s1_p1;
  logic s1_range;
  logic s1_adv;
  logic signed [tes_pkg::DiffW-1:0] dx1, dy2, dx2, dy1;
  logic signed [tes_pkg::DetW-1:0] det;
  logic [2:0] oob;

  assign s1_adv = !job_valid || job_ready;
  assign in.ready = !s1_valid || s1_adv;

  always_comb begin
    dx1 = tes_pkg::DiffW'(in.data.x_second) - tes_pkg::DiffW'(in.data.x_first);
    dy2 = tes_pkg::DiffW'(in.data.y_third) - tes_pkg::DiffW'(in.data.y_first);
    dx2 = tes_pkg::DiffW'(in.data.x_third) - tes_pkg::DiffW'(in.data.x_first);
    dy1 = tes_pkg::DiffW'(in.data.y_second) - tes_pkg::DiffW'(in.data.y_first);
    oob[0] = 32'(in.data.node_first) >= MAX_NODES;
    oob[1] = 32'(in.data.node_second) >= MAX_NODES;
    oob[2] = 32'(in.data.node_third) >= MAX_NODES;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in.ready) begin
      s1_valid <= in.valid;
    end
    if (in.valid && in.ready) begin
      s1_node <= {in.data.node_third, in.data.node_second, in.data.node_first};
      s1_bb[0] <= tes_pkg::DiffW'(in.data.y_second) - tes_pkg::DiffW'(in.data.y_third);
      s1_bb[1] <= tes_pkg::DiffW'(in.data.y_third) - tes_pkg::DiffW'(in.data.y_first);
      s1_bb[2] <= tes_pkg::DiffW'(in.data.y_first) - tes_pkg::DiffW'(in.data.y_second);
      s1_cc[0] <= tes_pkg::DiffW'(in.data.x_third) - tes_pkg::DiffW'(in.data.x_second);
      s1_cc[1] <= tes_pkg::DiffW'(in.data.x_first) - tes_pkg::DiffW'(in.data.x_third);
      s1_cc[2] <= tes_pkg::DiffW'(in.data.x_second) - tes_pkg::DiffW'(in.data.x_first);
      s1_p0 <= dx1 * dy2;
      s1_p1 <= dx2 * dy1;
      s1_range <= |oob;
    end
  end

  // Stage 2: determinant magnitude and zero-area or out-of-range classification.
  always_comb det = tes_pkg::DetW'(s1_p0) - tes_pkg::DetW'(s1_p1);

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (s1_adv) begin
      job_valid <= s1_valid;
    end
    if (s1_adv && s1_valid) begin
      job.node <= s1_node;
      job.bb <= s1_bb;
      job.cc <= s1_cc;
      job.det_mag <= det[tes_pkg::DetW-1] ? -det : det;
      job.zero <= (det == '0) || s1_range;
    end
  end
endmodule

// ===== design/tes_queue.sv =====
module tes_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  tes_pkg::job_t push_data,
  output logic full,
  output logic empty,
  input  logic pop,
  output tes_pkg::job_t pop_data
);
  localparam int unsigned AW = $clog2(tes_pkg::QueueDepth);
  tes_pkg::job_t mem [tes_pkg::QueueDepth];
  logic [AW-1:0] wp, rp;
  logic [AW:0] count;

  assign full = count == (AW+1)'(tes_pkg::QueueDepth);
  assign empty = count == '0;
  assign pop_data = mem[rp];

  // Hold entries in a small circular buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
    if (push) mem[wp] <= push_data;
  end
endmodule

// ===== design/tes_back.sv =====
module tes_back (
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  input  tes_pkg::job_t job,
  output logic job_pop,
  tes_stream_if.source out
);
  typedef enum logic [1:0] {IDLE, MULT, DIVIDE, EMIT} state_t;
  state_t state;
  logic [1:0] a, b;
  logic [6:0] step;
  logic signed [tes_pkg::ProdW-1:0] pb, pc;
  logic [tes_pkg::DivW-1:0] rem;
  logic [tes_pkg::QW-1:0] quo;
  logic [tes_pkg::DivW-1:0] dividend;
  logic neg;
  logic [tes_pkg::DivW:0] trial;
  logic [tes_pkg::DivW-1:0] rem_sh;
  logic signed [tes_pkg::NumW-1:0] num;
  logic [tes_pkg::QW-1:0] q_rnd;
  logic [tes_pkg::ValW-1:0] val;
  logic sat;

  // Restoring division, one quotient bit per cycle; also the numerator, rounding and saturation.
  always_comb begin
    rem_sh = {rem[tes_pkg::DivW-2:0], dividend[tes_pkg::DivW-1]};
    trial = {1'b0, rem_sh} - {{(tes_pkg::DivW-tes_pkg::DetW+1){1'b0}}, job.det_mag};
    num = tes_pkg::NumW'(pb) + tes_pkg::NumW'(pc);
    q_rnd = quo + tes_pkg::QW'({rem, 1'b0} >= {{(tes_pkg::DivW-tes_pkg::DetW+1){1'b0}},
                                               job.det_mag});
    sat = 1'b0;
    if (!neg) begin
      if (q_rnd > tes_pkg::QW'(32'h7fff_ffff)) begin
        sat = 1'b1;
        val = 32'h7fff_ffff;
      end else val = q_rnd[31:0];
    end else begin
      if (q_rnd > tes_pkg::QW'(33'h0_8000_0000)) begin
        sat = 1'b1;
        val = 32'h8000_0000;
      end else val = 32'd0 - q_rnd[31:0];
    end
  end

  assign job_pop = (state == EMIT) && out.ready && a == 2'd2 && b == 2'd2 && !out.valid
                   ? 1'b0 : (out.valid && out.ready && out.data.last_entry);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      out.valid <= 1'b0;
      a <= '0;
      b <= '0;
    end else begin
      // Drop the output request once taken, unless a new entry replaces it.
      if (out.valid && out.ready && state != EMIT) out.valid <= 1'b0;
      case (state)
        IDLE: begin
          if (job_valid && !(out.valid && out.data.last_entry)) state <= MULT;
        end
        MULT: begin
          pb <= $signed(job.bb[a]) * $signed(job.bb[b]);
          pc <= $signed(job.cc[a]) * $signed(job.cc[b]);
          state <= job.zero ? EMIT : DIVIDE;
          step <= 7'd0;
        end
        DIVIDE: begin
          if (step == 7'd0) begin
            neg <= num[tes_pkg::NumW-1];
            dividend <= tes_pkg::DivW'(num[tes_pkg::NumW-1] ? -num : num) << 15;
            rem <= '0;
            quo <= '0;
            step <= 7'd1;
          end else begin
            dividend <= dividend << 1;
            if (!trial[tes_pkg::DivW]) begin
              rem <= trial[tes_pkg::DivW-1:0];
              quo <= {quo[tes_pkg::QW-2:0], 1'b1};
            end else begin
              rem <= rem_sh;
              quo <= {quo[tes_pkg::QW-2:0], 1'b0};
            end
            if (step == 7'(tes_pkg::DivW)) state <= EMIT;
            else step <= step + 7'd1;
          end
        end
        EMIT: begin
          if (!out.valid || out.ready) begin
            out.valid <= 1'b1;
            out.data.row_node <= job.node[a];
            out.data.column_node <= job.node[b];
            out.data.contribution <= job.zero ? '0 : val;
            out.data.degenerate <= job.zero;
            out.data.saturated <= job.zero ? 1'b0 : sat;
            out.data.last_entry <= a == 2'd2 && b == 2'd2;
            if (b == 2'd2) begin
              b <= '0;
              a <= (a == 2'd2) ? 2'd0 : a + 2'd1;
            end else b <= b + 2'd1;
            state <= (a == 2'd2 && b == 2'd2) ? IDLE : MULT;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

// ===== design/triangle_element_stiffness_unit.sv =====
// Triangle element stiffness unit.
// Input channel "in" takes one triangle per request: three node indices and
// three vertex coordinates in signed Q12.12. Output channel "out" gives nine
// (row, column, contribution) requests per triangle, row-major over vertex
// positions, with last_entry on the ninth; contributions are Q16.16.
// A two-stage front forms edge differences and the area determinant and
// flags zero-area or out-of-range triangles; a two-entry queue feeds the back.
// The back forms each entry's numerator and runs a restoring divider that
// yields one quotient bit per cycle and sets the rate for regular
// triangles; degenerate entries skip the divider and give zero.
// Reset clears all valid flags and the queue; no results are pending after.
// When the receiver stalls, the output register holds and the back waits;
// the front keeps accepting until the queue fills.
`include "triangle_element_stiffness_unit_defines.svh"
module triangle_element_stiffness_unit #(
  parameter int unsigned MAX_NODES = tes_pkg::MaxNodesDefault
) (
  input logic clk,
  input logic rst,
  tes_stream_if.sink in,
  tes_stream_if.source out
);
  logic fr_valid, q_full, q_empty, q_pop;
  tes_pkg::job_t fr_job, q_job;

  tes_front #(.MAX_NODES(MAX_NODES)) u_front (
    .clk, .rst, .in, .job_valid(fr_valid), .job(fr_job), .job_ready(!q_full)
  );

  tes_queue u_queue (
    .clk, .rst, .push(fr_valid && !q_full), .push_data(fr_job), .full(q_full),
    .empty(q_empty), .pop(q_pop), .pop_data(q_job)
  );

  tes_back u_back (
    .clk, .rst, .job_valid(!q_empty), .job(q_job), .job_pop(q_pop), .out
  );

  `TES_ASSERT_IMP(a_pop_nonempty, clk, rst, q_pop, !q_empty)
  `TES_ASSERT_IMP(a_degen_zero, clk, rst, out.valid && out.data.degenerate,
    out.data.contribution == '0 && !out.data.saturated)
  `TES_ASSERT_NEXT(a_out_hold, clk, rst, out.valid && !out.ready, out.valid)
endmodule

// ===== tb/sv/triangle_element_stiffness_unit_tb.sv =====
`timescale 1ns / 100ps

module triangle_element_stiffness_unit_tb;

  localparam int unsigned MaxNodes = 65536;
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned RandomTriangles = 200;

  // Holds the stiffness entries still owed by the block and checks arrivals.
  class stiffness_scoreboard;
    tes_pkg::entry_t owed[$];
    int unsigned mismatches;

    // Form one Q16.16 entry: |num| * 2^15 / |det|, round half away, sign, clip.
    function automatic void entry_value(input longint num, input longint det,
                                        output logic [31:0] val, output logic sat);
      logic [127:0] mag;
      logic [127:0] dmag;
      logic [127:0] q;
      logic [127:0] r;
      logic neg;
      neg = num < 0;
      mag = neg ? 128'(-num) : 128'(num);
      dmag = det < 0 ? 128'(-det) : 128'(det);
      mag = mag << 15;
      q = mag / dmag;
      r = mag % dmag;
      if (2 * r >= dmag) q = q + 1;
      sat = 1'b0;
      if (!neg) begin
        if (q > 128'h7FFFFFFF) begin
          sat = 1'b1;
          q = 128'h7FFFFFFF;
        end
        val = q[31:0];
      end else begin
        if (q > 128'h80000000) begin
          sat = 1'b1;
          q = 128'h80000000;
        end
        val = 32'd0 - q[31:0];
      end
    endfunction

    // Note an accepted triangle: predict its nine entries in row-major order.
    function automatic void note_triangle(input tes_pkg::tri_t t);
      longint xs[3];
      longint ys[3];
      longint bb[3];
      longint cc[3];
      logic [15:0] nd[3];
      longint det;
      logic zero;
      tes_pkg::entry_t e;
      logic [31:0] val;
      logic sat;
      nd[0] = t.node_first; nd[1] = t.node_second; nd[2] = t.node_third;
      xs[0] = longint'(t.x_first); ys[0] = longint'(t.y_first);
      xs[1] = longint'(t.x_second); ys[1] = longint'(t.y_second);
      xs[2] = longint'(t.x_third); ys[2] = longint'(t.y_third);
      for (int k = 0; k < 3; k++) begin
        bb[k] = ys[(k + 1) % 3] - ys[(k + 2) % 3];
        cc[k] = xs[(k + 2) % 3] - xs[(k + 1) % 3];
      end
      det = (xs[1] - xs[0]) * (ys[2] - ys[0]) - (xs[2] - xs[0]) * (ys[1] - ys[0]);
      zero = (det == 0);
      for (int k = 0; k < 3; k++)
        if (32'(nd[k]) >= MaxNodes) zero = 1'b1;
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          val = '0;
          sat = 1'b0;
          if (!zero) entry_value(bb[a] * bb[b] + cc[a] * cc[b], det, val, sat);
          e.row_node = nd[a];
          e.column_node = nd[b];
          e.contribution = val;
          e.degenerate = zero;
          e.saturated = sat;
          e.last_entry = (a == 2 && b == 2);
          owed.push_back(e);
        end
      end
    endfunction

    // Compare one arrived entry against the oldest owed one.
    function automatic void check_entry(input tes_pkg::entry_t got);
      tes_pkg::entry_t want;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected entry %p", got);
        return;
      end
      want = owed.pop_front();
      if (got.row_node !== want.row_node || got.column_node !== want.column_node ||
          got.contribution !== want.contribution ||
          got.degenerate !== want.degenerate || got.saturated !== want.saturated ||
          got.last_entry !== want.last_entry) begin
        mismatches++;
        if (mismatches <= 10) $display("entry mismatch: expected %p got %p", want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  tes_stream_if #(.payload_t(tes_pkg::tri_t)) tri_ch (clk);
  tes_stream_if #(.payload_t(tes_pkg::entry_t)) entry_ch (clk);

  triangle_element_stiffness_unit uut (
    .clk(clk),
    .rst(rst),
    .in(tri_ch.sink),
    .out(entry_ch.source)
  );

  always #2 clk = ~clk;

  stiffness_scoreboard board = new();
  bit sending_done = 1'b0;
  bit hold_off = 1'b0;
  int unsigned idle_cycles = 0;

  initial begin
    tri_ch.valid = 1'b0;
    tri_ch.data = '0;
    entry_ch.ready = 1'b0;
  end

  function automatic int unsigned gap_length();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  function automatic logic signed [23:0] random_coord();
    case ($urandom_range(0, 3))
      0: return 24'($urandom());
      1: return 24'sh800000 | 24'($urandom_range(0, 15));
      2: return 24'sh7FFFF0 | 24'($urandom_range(0, 15));
      default: return 24'(signed'($urandom_range(0, 16383)) - 8192);
    endcase
  endfunction

  // Offer one triangle and wait until it is accepted; if gaps is set, insert a random gap first.
  task automatic send_triangle(input tes_pkg::tri_t t, input bit gaps);
    int unsigned g;
    g = gaps ? gap_length() : 0;
    repeat (g) @(negedge clk);
    tri_ch.data = t;
    tri_ch.valid = 1'b1;
    do @(posedge clk); while (!tri_ch.ready);
    board.note_triangle(t);
    @(negedge clk);
    tri_ch.valid = 1'b0;
  endtask

  function automatic tes_pkg::tri_t make_triangle(input int unsigned n0,
                                                  input int unsigned n1,
                                                  input int unsigned n2, input int x0,
                                                  input int y0, input int x1, input int y1,
                                                  input int x2, input int y2);
    tes_pkg::tri_t t;
    t.node_first = 16'(n0); t.node_second = 16'(n1); t.node_third = 16'(n2);
    t.x_first = 24'(x0); t.y_first = 24'(y0);
    t.x_second = 24'(x1); t.y_second = 24'(y1);
    t.x_third = 24'(x2); t.y_third = 24'(y2);
    return t;
  endfunction

  // Random triangle: mostly well-formed small triangles, some at full range.
  function automatic tes_pkg::tri_t random_triangle();
    tes_pkg::tri_t t;
    int base_x;
    int base_y;
    t.node_first = 16'($urandom());
    t.node_second = 16'($urandom());
    t.node_third = 16'($urandom());
    if ($urandom_range(0, 9) == 0) t.node_second = t.node_first;
    if ($urandom_range(0, 3) == 0) begin
      t.x_first = random_coord(); t.y_first = random_coord();
      t.x_second = random_coord(); t.y_second = random_coord();
      t.x_third = random_coord(); t.y_third = random_coord();
    end else begin
      base_x = signed'($urandom_range(0, 32'hFFFFF)) - 32'h80000;
      base_y = signed'($urandom_range(0, 32'hFFFFF)) - 32'h80000;
      t.x_first = 24'(base_x); t.y_first = 24'(base_y);
      t.x_second = 24'(base_x + signed'($urandom_range(0, 16384)) - 8192);
      t.y_second = 24'(base_y + signed'($urandom_range(0, 16384)) - 8192);
      t.x_third = 24'(base_x + signed'($urandom_range(0, 16384)) - 8192);
      t.y_third = 24'(base_y + signed'($urandom_range(0, 16384)) - 8192);
      if ($urandom_range(0, 11) == 0) begin
        // collinear: third vertex on the line through the first two
        t.x_third = 24'(2 * int'(t.x_second) - int'(t.x_first));
        t.y_third = 24'(2 * int'(t.y_second) - int'(t.y_first));
      end
    end
    return t;
  endfunction

  // Drive the input side: directed triangles, then random ones.
  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // unit right triangle, its mirror and a tiny one
    send_triangle(make_triangle(0, 1, 2, 0, 0, 4096, 0, 0, 4096), 1'b0);
    send_triangle(make_triangle(5, 6, 7, 0, 0, 0, 4096, 4096, 0), 1'b0);
    send_triangle(make_triangle(1, 2, 3, 0, 0, 1, 0, 0, 1), 1'b0);
    // huge triangle across the whole coordinate range
    send_triangle(make_triangle(65535, 0, 32768, -8388608, -8388608, 8388607, -8388608,
                                -8388608, 8388607), 1'b0);
    // sliver: very thin, large entries saturate
    send_triangle(make_triangle(10, 11, 12, -8388608, 0, 8388607, 0, 0, 1), 1'b0);
    send_triangle(make_triangle(10, 11, 12, -8388608, 1, 8388607, -1, 0, 0), 1'b0);
    // zero area: coincident points and collinear points
    send_triangle(make_triangle(4, 5, 6, 100, 100, 100, 100, 100, 100), 1'b0);
    send_triangle(make_triangle(4, 5, 6, 0, 0, 4096, 4096, 8192, 8192), 1'b0);
    send_triangle(make_triangle(65535, 65535, 65535, 8388607, 8388607, -8388608, -8388608,
                                8388607, 8388607), 1'b0);
    // repeated node index with a regular triangle
    send_triangle(make_triangle(9, 9, 3, 0, 0, 8192, 0, 4096, 4096), 1'b0);
    send_triangle(make_triangle(7, 8, 7, -4096, -4096, 4096, -4096, 0, 4096), 1'b1);
    send_triangle(make_triangle(16'hAAAA, 16'h5555, 16'hFFFF, 24'h555555, -24'sh2AAAAA,
                                -24'sh555556, 24'h2AAAAA, 24'h123456, -24'sh654321), 1'b1);
    // receiver holds off while triangles keep coming, filling the queue
    hold_off = 1'b1;
    for (int i = 0; i < 6; i++) send_triangle(random_triangle(), 1'b0);
    for (int i = 0; i < RandomTriangles; i++) send_triangle(random_triangle(), 1'b1);
    sending_done = 1'b1;
  end

  // Drive the output side: random stalls plus one long hold-off.
  initial begin
    int unsigned g;
    bit held;
    held = 1'b0;
    @(negedge clk);
    while (1) begin
      if (hold_off && !held) begin
        entry_ch.ready = 1'b0;
        repeat (3000) @(negedge clk);
        held = 1'b1;
      end
      g = ($urandom_range(0, 3) == 0) ? gap_length() : 0;
      entry_ch.ready = (g == 0);
      if (g == 0) @(negedge clk);
      else repeat (g) @(negedge clk);
    end
  end

  // Check every accepted entry at the rising edge; count idle cycles.
  always @(posedge clk) begin
    if (!rst) begin
      if (entry_ch.valid && entry_ch.ready) board.check_entry(entry_ch.data);
      if ((entry_ch.valid && entry_ch.ready) || (tri_ch.valid && tri_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Finish once everything is drained, or on a stall.
  initial begin
    while (!(sending_done && board.owed.size() == 0)) @(posedge clk);
    repeat (800) @(posedge clk);
    if (board.mismatches == 0 && board.owed.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    wait (idle_cycles >= StallLimit);
    $display("watchdog: no progress, %0d entries owed", board.owed.size());
    $display("*** FAILED ***");
    $finish;
  end
endmodule
